>>> hw/rtl/mwsm_pkg.sv
// Shared types, widths and constants for the mecanum wheel speed mixer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mwsm_pkg;

  // Fixed-point formats of the two ratio registers
  localparam int TURN_FRAC    = 8;
  localparam int RPM_FRAC     = 24;

  // Field and register widths
  localparam int CMD_W        = 16;
  localparam int LIM_W        = 15;
  localparam int TURN_RATIO_W = 16;
  localparam int RPM_RATIO_W  = 24;
  localparam int WHEEL_W      = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int N_LANES      = 4;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Datapath widths
  localparam int LIN_W      = CMD_W + 1;
  localparam int TURN_W     = CMD_W + TURN_RATIO_W + 1;
  localparam int MIX_W      = imax(TURN_W, LIN_W + TURN_FRAC) + 1;
  localparam int MIXMAG_W   = MIX_W - 1;
  localparam int PROD_W     = MIXMAG_W + RPM_RATIO_W;
  localparam int RPM_SHIFT  = TURN_FRAC + RPM_FRAC;
  localparam int HI_W       = PROD_W - RPM_SHIFT;
  localparam int SAT_W      = imax(HI_W, LIM_W);
  localparam int DVD_W      = 2 * LIM_W;

  // Pipeline shape
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = (LIM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int FE_STAGES   = 6;
  localparam int SC_STAGES   = 2;
  localparam int PIPE_STAGES = FE_STAGES + SC_STAGES + DIV_STAGES;

  localparam logic [LIM_W-1:0]   WHEEL_SAT       = '1;
  localparam logic [WHEEL_W-1:0] WHEEL_NEG_LIMIT = {1'b1, {(WHEEL_W-1){1'b0}}};

  // Register reset values
  localparam logic [LIM_W-1:0]        LIMIT_X_RST     = LIM_W'(3500);
  localparam logic [LIM_W-1:0]        LIMIT_Y_RST     = LIM_W'(3500);
  localparam logic [LIM_W-1:0]        LIMIT_TURN_RST  = LIM_W'(300);
  localparam logic [TURN_RATIO_W-1:0] TURN_RATIO_RST  = TURN_RATIO_W'(2345);
  localparam logic [RPM_RATIO_W-1:0]  RPM_RATIO_RST   = RPM_RATIO_W'(110846);
  localparam logic [LIM_W-1:0]        WHEEL_LIMIT_RST = LIM_W'(8500);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_X     = 3'd0,
    CFG_LIMIT_Y     = 3'd1,
    CFG_LIMIT_TURN  = 3'd2,
    CFG_TURN_RATIO  = 3'd3,
    CFG_RPM_RATIO   = 3'd4,
    CFG_WHEEL_LIMIT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [LIM_W-1:0]        limit_x;
    logic [LIM_W-1:0]        limit_y;
    logic [LIM_W-1:0]        limit_turn;
    logic [TURN_RATIO_W-1:0] turn_ratio;
    logic [RPM_RATIO_W-1:0]  rpm_ratio;
    logic [LIM_W-1:0]        wheel_limit;
  } cfg_regs_t;

  // Per-stage load enables, grouped by the module that owns the stages
  typedef struct packed {
    logic [FE_STAGES-1:0]  fe;
    logic [SC_STAGES-1:0]  sc;
    logic [DIV_STAGES-1:0] dv;
  } stage_en_t;

endpackage

>>> hw/rtl/mecanum_wheel_speed_mixer_unit.sv
// Top level of the mecanum wheel speed mixer: configuration registers,
// pipeline flow control and output register. Depends on mwsm_pkg,
// mwsm_mix, mwsm_scale and mwsm_div.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one chassis command, the
//   three speeds, per transaction; the result channel (out_valid/out_ready)
//   returns the four wheel speeds in rpm and the scaling flag.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   writes one register per transaction; cfg_ready is always high and
//   indexes beyond the register list are dropped. Write only while idle.
//   An input transaction passes through the six front-end stages, two
//   limit-check stages, four divider stages (up to four quotient bits each)
//   and the output register, which drives out_valid.
//   Throughput: one transaction per cycle while the receiver does not stall.
//   Reset clears every valid bit and loads the register defaults.
//   While the receiver stalls, the output holds, the stages behind it close
//   up their bubbles, and in_ready drops only once all stages are full.
`timescale 1ns / 1ps

module mecanum_wheel_speed_mixer_unit import mwsm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [CMD_W-1:0]      in_speed_x,
  input  logic signed [CMD_W-1:0]      in_speed_y,
  input  logic signed [CMD_W-1:0]      in_turn_rate,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WHEEL_W-1:0]    out_wheel0_rpm,
  output logic signed [WHEEL_W-1:0]    out_wheel1_rpm,
  output logic signed [WHEEL_W-1:0]    out_wheel2_rpm,
  output logic signed [WHEEL_W-1:0]    out_wheel3_rpm,
  output logic                         out_was_scaled,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  cfg_regs_t                     cfg_r;
  logic [PIPE_STAGES-1:0]        valid_r;
  logic                          out_valid_r;
  logic [PIPE_STAGES:0]          adv;
  stage_en_t                     stage_en;

  logic [N_LANES-1:0][LIM_W-1:0] fe_mag, sc_mag, dv_mag, dv_quo;
  logic [N_LANES-1:0]            fe_neg, sc_neg, dv_neg;
  logic [N_LANES-1:0][DVD_W-1:0] sc_dvd;
  logic [LIM_W-1:0]              sc_dvs;
  logic                          sc_scaled, dv_scaled;

  logic [WHEEL_W-1:0]            wheel_r   [N_LANES];
  logic [WHEEL_W-1:0]            wheel_nxt [N_LANES];
  logic                          scaled_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_x     <= LIMIT_X_RST;
      cfg_r.limit_y     <= LIMIT_Y_RST;
      cfg_r.limit_turn  <= LIMIT_TURN_RST;
      cfg_r.turn_ratio  <= TURN_RATIO_RST;
      cfg_r.rpm_ratio   <= RPM_RATIO_RST;
      cfg_r.wheel_limit <= WHEEL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LIMIT_X:     cfg_r.limit_x     <= cfg_data[LIM_W-1:0];
        CFG_LIMIT_Y:     cfg_r.limit_y     <= cfg_data[LIM_W-1:0];
        CFG_LIMIT_TURN:  cfg_r.limit_turn  <= cfg_data[LIM_W-1:0];
        CFG_TURN_RATIO:  cfg_r.turn_ratio  <= cfg_data[TURN_RATIO_W-1:0];
        CFG_RPM_RATIO:   cfg_r.rpm_ratio   <= cfg_data[RPM_RATIO_W-1:0];
        CFG_WHEEL_LIMIT: cfg_r.wheel_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: a stage loads when it is empty or its successor moves on
  always_comb begin
    adv[PIPE_STAGES] = !out_valid_r || out_ready;
    for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
  end

  assign in_ready    = adv[0];
  assign stage_en.fe = adv[FE_STAGES-1:0];
  assign stage_en.sc = adv[FE_STAGES+SC_STAGES-1:FE_STAGES];
  assign stage_en.dv = adv[PIPE_STAGES-1:FE_STAGES+SC_STAGES];

  // Valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (adv[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
      if (adv[PIPE_STAGES]) begin
        out_valid_r <= valid_r[PIPE_STAGES-1];
      end
    end
  end

  mwsm_mix u_mix (
    .clk       (clk),
    .en        (stage_en),
    .cfg       (cfg_r),
    .speed_x   (in_speed_x),
    .speed_y   (in_speed_y),
    .turn_rate (in_turn_rate),
    .mag       (fe_mag),
    .neg       (fe_neg)
  );

  mwsm_scale u_scale (
    .clk     (clk),
    .en      (stage_en),
    .cfg     (cfg_r),
    .mag_in  (fe_mag),
    .neg_in  (fe_neg),
    .dvd     (sc_dvd),
    .dvs     (sc_dvs),
    .mag_out (sc_mag),
    .neg_out (sc_neg),
    .scaled  (sc_scaled)
  );

  mwsm_div u_div (
    .clk        (clk),
    .en         (stage_en),
    .dvd        (sc_dvd),
    .dvs        (sc_dvs),
    .mag_in     (sc_mag),
    .neg_in     (sc_neg),
    .scaled_in  (sc_scaled),
    .quo        (dv_quo),
    .mag_out    (dv_mag),
    .neg_out    (dv_neg),
    .scaled_out (dv_scaled)
  );

  // Output register: pick scaled or plain magnitude and restore the sign
  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      if (dv_neg[l]) begin
        wheel_nxt[l] = -WHEEL_W'(dv_scaled ? dv_quo[l] : dv_mag[l]);
      end else begin
        wheel_nxt[l] = WHEEL_W'(dv_scaled ? dv_quo[l] : dv_mag[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[PIPE_STAGES]) begin
      wheel_r  <= wheel_nxt;
      scaled_r <= dv_scaled;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_wheel0_rpm = wheel_r[0];
  assign out_wheel1_rpm = wheel_r[1];
  assign out_wheel2_rpm = wheel_r[2];
  assign out_wheel3_rpm = wheel_r[3];
  assign out_was_scaled = scaled_r;

  // Back-pressure reaches the input only with every stage occupied
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&valid_r) && out_valid_r && !out_ready)
    else $error("in_ready low with a free pipeline stage");

  // No transaction is lost or duplicated inside the pipeline
  a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      $countones({out_valid_r, valid_r}) ==
      $countones($past({out_valid_r, valid_r}))
        + ($past(in_valid && in_ready) ? 1 : 0)
        - ($past(out_valid_r && out_ready) ? 1 : 0))
    else $error("pipeline occupancy does not match transactions");

  // Saturation and sign restore never give the most negative code
  a_no_neg_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (wheel_r[0] != WHEEL_NEG_LIMIT) && (wheel_r[1] != WHEEL_NEG_LIMIT)
                 && (wheel_r[2] != WHEEL_NEG_LIMIT) && (wheel_r[3] != WHEEL_NEG_LIMIT))
    else $error("wheel speed out of the symmetric range");

endmodule

>>> hw/rtl/mwsm_mix.sv
// Front end of the mixer: clamp, turn product, four-wheel mix, rpm conversion
// and saturation, six register stages. Depends on mwsm_pkg.
`timescale 1ns / 1ps

module mwsm_mix import mwsm_pkg::*; (
  input  logic                              clk,
  input  stage_en_t                         en,
  input  cfg_regs_t                         cfg,
  input  logic signed [CMD_W-1:0]           speed_x,
  input  logic signed [CMD_W-1:0]           speed_y,
  input  logic signed [CMD_W-1:0]           turn_rate,
  output logic [N_LANES-1:0][LIM_W-1:0]     mag,
  output logic [N_LANES-1:0]                neg
);

  function automatic logic signed [CMD_W-1:0] clamp_sym(
    input logic signed [CMD_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [CMD_W:0]   v_e;
    logic signed [CMD_W:0]   l_e;
    logic signed [CMD_W-1:0] res;
    v_e = (CMD_W+1)'(v);
    l_e = signed'({{(CMD_W+1-LIM_W){1'b0}}, lim});
    if (v_e > l_e) begin
      res = CMD_W'(l_e);
    end else if (v_e < -l_e) begin
      res = CMD_W'(-l_e);
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic signed [CMD_W-1:0]    x1_r, y1_r, w1_r;
  logic signed [LIN_W-1:0]    lin_r [N_LANES];
  logic signed [LIN_W-1:0]    lin_nxt [N_LANES];
  logic signed [TURN_W-1:0]   turn_r, turn_nxt;
  logic signed [TURN_RATIO_W:0] ratio_s;
  logic signed [MIX_W-1:0]    mix_r [N_LANES];
  logic [MIXMAG_W-1:0]        mag4_r [N_LANES];
  logic [N_LANES-1:0]         neg4_r, neg5_r, neg6_r;
  logic [PROD_W-1:0]          prod_r [N_LANES];
  logic [LIM_W-1:0]           mag6_r [N_LANES];

  // Stage 1: clamp each command to its symmetric limit
  always_ff @(posedge clk) begin
    if (en.fe[0]) begin
      x1_r <= clamp_sym(speed_x, cfg.limit_x);
      y1_r <= clamp_sym(speed_y, cfg.limit_y);
      w1_r <= clamp_sym(turn_rate, cfg.limit_turn);
    end
  end

  // Stage 2: linear sign patterns and the turn product
  assign ratio_s  = signed'({1'b0, cfg.turn_ratio});
  assign turn_nxt = TURN_W'(w1_r) * TURN_W'(ratio_s);

  always_comb begin
    lin_nxt[0] =  LIN_W'(x1_r) + LIN_W'(y1_r);
    lin_nxt[1] =  LIN_W'(y1_r) - LIN_W'(x1_r);
    lin_nxt[2] = -LIN_W'(x1_r) - LIN_W'(y1_r);
    lin_nxt[3] =  LIN_W'(x1_r) - LIN_W'(y1_r);
  end

  always_ff @(posedge clk) begin
    if (en.fe[1]) begin
      lin_r  <= lin_nxt;
      turn_r <= turn_nxt;
    end
  end

  // Stage 3: align the linear term to the turn fraction and add
  always_ff @(posedge clk) begin
    if (en.fe[2]) begin
      for (int l = 0; l < N_LANES; l++) begin
        mix_r[l] <= (MIX_W'(lin_r[l]) <<< TURN_FRAC) + MIX_W'(turn_r);
      end
    end
  end

  // Stage 4: split into sign and magnitude
  always_ff @(posedge clk) begin
    if (en.fe[3]) begin
      for (int l = 0; l < N_LANES; l++) begin
        neg4_r[l] <= mix_r[l][MIX_W-1];
        mag4_r[l] <= mix_r[l][MIX_W-1] ? MIXMAG_W'(-mix_r[l]) : MIXMAG_W'(mix_r[l]);
      end
    end
  end

  // Stage 5: convert to rpm
  always_ff @(posedge clk) begin
    if (en.fe[4]) begin
      neg5_r <= neg4_r;
      for (int l = 0; l < N_LANES; l++) begin
        prod_r[l] <= PROD_W'(mag4_r[l]) * PROD_W'(cfg.rpm_ratio);
      end
    end
  end

  // Stage 6: drop the fraction and saturate the magnitude
  always_ff @(posedge clk) begin
    if (en.fe[5]) begin
      neg6_r <= neg5_r;
      for (int l = 0; l < N_LANES; l++) begin
        if (SAT_W'(prod_r[l][PROD_W-1:RPM_SHIFT]) > SAT_W'(WHEEL_SAT)) begin
          mag6_r[l] <= WHEEL_SAT;
        end else begin
          mag6_r[l] <= LIM_W'(prod_r[l][PROD_W-1:RPM_SHIFT]);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      mag[l] = mag6_r[l];
    end
  end
  assign neg = neg6_r;

endmodule

>>> hw/rtl/mwsm_scale.sv
// Wheel-limit check: largest magnitude, scaling flag and scaled dividends,
// two register stages. Depends on mwsm_pkg.
`timescale 1ns / 1ps

module mwsm_scale import mwsm_pkg::*; (
  input  logic                              clk,
  input  stage_en_t                         en,
  input  cfg_regs_t                         cfg,
  input  logic [N_LANES-1:0][LIM_W-1:0]     mag_in,
  input  logic [N_LANES-1:0]                neg_in,
  output logic [N_LANES-1:0][DVD_W-1:0]     dvd,
  output logic [LIM_W-1:0]                  dvs,
  output logic [N_LANES-1:0][LIM_W-1:0]     mag_out,
  output logic [N_LANES-1:0]                neg_out,
  output logic                              scaled
);

  function automatic logic [LIM_W-1:0] umax(
    input logic [LIM_W-1:0] a,
    input logic [LIM_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  logic [N_LANES-1:0][LIM_W-1:0] mag7_r, mag8_r;
  logic [N_LANES-1:0]            neg7_r, neg8_r;
  logic [LIM_W-1:0]              max7_r, max8_r;
  logic [N_LANES-1:0][DVD_W-1:0] dvd8_r;
  logic                          scl8_r;

  // Stage 7: largest wheel magnitude through a two-level compare tree
  always_ff @(posedge clk) begin
    if (en.sc[0]) begin
      mag7_r <= mag_in;
      neg7_r <= neg_in;
      max7_r <= umax(umax(mag_in[0], mag_in[1]), umax(mag_in[2], mag_in[3]));
    end
  end

  // Stage 8: flag the overshoot and form magnitude times limit
  always_ff @(posedge clk) begin
    if (en.sc[1]) begin
      mag8_r <= mag7_r;
      neg8_r <= neg7_r;
      max8_r <= max7_r;
      scl8_r <= max7_r > cfg.wheel_limit;
      for (int l = 0; l < N_LANES; l++) begin
        dvd8_r[l] <= DVD_W'(mag7_r[l]) * DVD_W'(cfg.wheel_limit);
      end
    end
  end

  assign dvd     = dvd8_r;
  assign dvs     = max8_r;
  assign mag_out = mag8_r;
  assign neg_out = neg8_r;
  assign scaled  = scl8_r;

endmodule

>>> hw/rtl/mwsm_div.sv
// Pipelined restoring divider, four lanes sharing one divisor, a few
// quotient bits per stage. Depends on mwsm_pkg.
`timescale 1ns / 1ps

module mwsm_div import mwsm_pkg::*; (
  input  logic                              clk,
  input  stage_en_t                         en,
  input  logic [N_LANES-1:0][DVD_W-1:0]     dvd,
  input  logic [LIM_W-1:0]                  dvs,
  input  logic [N_LANES-1:0][LIM_W-1:0]     mag_in,
  input  logic [N_LANES-1:0]                neg_in,
  input  logic                              scaled_in,
  output logic [N_LANES-1:0][LIM_W-1:0]     quo,
  output logic [N_LANES-1:0][LIM_W-1:0]     mag_out,
  output logic [N_LANES-1:0]                neg_out,
  output logic                              scaled_out
);

  // The quotient never exceeds the limit, so the upper dividend half is
  // already below the divisor and seeds the partial remainder.
  logic [N_LANES-1:0][LIM_W-1:0] rem_r   [DIV_STAGES];
  logic [N_LANES-1:0][LIM_W-1:0] rem_src [DIV_STAGES];
  logic [N_LANES-1:0][LIM_W-1:0] rem_nxt [DIV_STAGES];
  logic [N_LANES-1:0][LIM_W-1:0] dq_r    [DIV_STAGES];
  logic [N_LANES-1:0][LIM_W-1:0] dq_src  [DIV_STAGES];
  logic [N_LANES-1:0][LIM_W-1:0] dq_nxt  [DIV_STAGES];
  logic [LIM_W-1:0]              dvs_r   [DIV_STAGES];
  logic [LIM_W-1:0]              dvs_src [DIV_STAGES];
  logic [N_LANES-1:0][LIM_W-1:0] mag_r   [DIV_STAGES];
  logic [N_LANES-1:0][LIM_W-1:0] mag_src [DIV_STAGES];
  logic [N_LANES-1:0]            neg_r   [DIV_STAGES];
  logic [N_LANES-1:0]            neg_src [DIV_STAGES];
  logic [DIV_STAGES-1:0]         scl_r, scl_src;

  // Select each stage's operands: the ports for the first, else the stage before
  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        for (int l = 0; l < N_LANES; l++) begin
          rem_src[s][l] = dvd[l][DVD_W-1:LIM_W];
          dq_src[s][l]  = dvd[l][LIM_W-1:0];
        end
        dvs_src[s] = dvs;
        mag_src[s] = mag_in;
        neg_src[s] = neg_in;
        scl_src[s] = scaled_in;
      end else begin
        rem_src[s] = rem_r[s-1];
        dq_src[s]  = dq_r[s-1];
        dvs_src[s] = dvs_r[s-1];
        mag_src[s] = mag_r[s-1];
        neg_src[s] = neg_r[s-1];
        scl_src[s] = scl_r[s-1];
      end
    end
  end

  // Shift in dividend bits and retire quotient bits, a few steps per stage
  always_comb begin
    logic [LIM_W:0]   t;
    logic [LIM_W-1:0] rem;
    logic [LIM_W-1:0] dq;
    logic             ge;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < N_LANES; l++) begin
        rem = rem_src[s][l];
        dq  = dq_src[s][l];
        for (int j = 0; j < DIV_STEPS; j++) begin
          if (s * DIV_STEPS + j < LIM_W) begin
            t  = {rem, dq[LIM_W-1]};
            ge = t >= {1'b0, dvs_src[s]};
            if (ge) begin
              rem = LIM_W'(t - {1'b0, dvs_src[s]});
            end else begin
              rem = t[LIM_W-1:0];
            end
            dq = {dq[LIM_W-2:0], ge};
          end
        end
        rem_nxt[s][l] = rem;
        dq_nxt[s][l]  = dq;
      end
    end
  end

  // Advance each stage when the pipeline control lets it load
  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en.dv[s]) begin
        rem_r[s] <= rem_nxt[s];
        dq_r[s]  <= dq_nxt[s];
        dvs_r[s] <= dvs_src[s];
        mag_r[s] <= mag_src[s];
        neg_r[s] <= neg_src[s];
        scl_r[s] <= scl_src[s];
      end
    end
  end

  assign quo        = dq_r[DIV_STAGES-1];
  assign mag_out    = mag_r[DIV_STAGES-1];
  assign neg_out    = neg_r[DIV_STAGES-1];
  assign scaled_out = scl_r[DIV_STAGES-1];

endmodule

>>> tb/sv/mecanum_wheel_speed_mixer_unit_test.sv
// Self-checking testbench for the mecanum wheel speed mixer: a directed table of commands
// and register writes, then randomised configuration phases, checked against a predictor
// or a hand-written result. Depends on mwsm_pkg and mecanum_wheel_speed_mixer_unit.
`timescale 1ns / 1ps

module mecanum_wheel_speed_mixer_unit_test;
  import mwsm_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int N_PHASES       = 10;
  localparam int CMDS_PER_PHASE = 140;
  localparam int N_REGS         = int'(CFG_WHEEL_LIMIT) + 1;
  localparam int MAX_REPORTS    = 200;

  // Indexes past the register list; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [N_LANES-1:0][WHEEL_W-1:0] rpm;
    logic                            scaled;
  } wheel_result_t;

  typedef enum logic [0:0] {
    ROW_CFG,
    ROW_CMD
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic signed [CMD_W-1:0] sx;
    logic signed [CMD_W-1:0] sy;
    logic signed [CMD_W-1:0] sw;
    logic                    fixed;   // expected result written out by hand
    wheel_result_t           want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [CMD_W-1:0]   in_speed_x = '0;
  logic signed [CMD_W-1:0]   in_speed_y = '0;
  logic signed [CMD_W-1:0]   in_turn_rate = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [WHEEL_W-1:0] out_wheel0_rpm;
  logic signed [WHEEL_W-1:0] out_wheel1_rpm;
  logic signed [WHEEL_W-1:0] out_wheel2_rpm;
  logic signed [WHEEL_W-1:0] out_wheel3_rpm;
  logic                      out_was_scaled;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  cfg_regs_t     chassis_cfg;
  wheel_result_t wheel_expect_q [$];
  stim_row_t     stim_rows [$];
  int            mismatches = 0;
  int            cycles = 0;
  int            in_calm_left = 0;
  int            out_calm_left = 0;
  int            out_stall_left = 0;

  mecanum_wheel_speed_mixer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_speed_x     (in_speed_x),
    .in_speed_y     (in_speed_y),
    .in_turn_rate   (in_turn_rate),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_wheel0_rpm (out_wheel0_rpm),
    .out_wheel1_rpm (out_wheel1_rpm),
    .out_wheel2_rpm (out_wheel2_rpm),
    .out_wheel3_rpm (out_wheel3_rpm),
    .out_was_scaled (out_was_scaled),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Symmetric clamp of a command; a zero bound forces zero
  function automatic longint clamp_cmd(logic signed [CMD_W-1:0] v, logic [LIM_W-1:0] bound);
    longint b;
    longint s;
    b = longint'(bound);
    s = longint'(v);
    if (s > b) return b;
    if (s < -b) return -b;
    return s;
  endfunction

  // Scale a mix to rpm: exact product, truncate toward zero, saturate
  function automatic longint wheel_rpm_of(longint mix);
    logic [63:0] mag;
    mag = (mix < 0) ? 64'(-mix) : 64'(mix);
    mag = (mag * 64'(chassis_cfg.rpm_ratio)) >> (TURN_FRAC + RPM_FRAC);
    if (mag > 64'(WHEEL_SAT)) mag = 64'(WHEEL_SAT);
    return (mix < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // Wheel speeds for one chassis command under the current register copy
  function automatic wheel_result_t mix_wheel_speeds(logic signed [CMD_W-1:0] sx,
                                                     logic signed [CMD_W-1:0] sy,
                                                     logic signed [CMD_W-1:0] sw);
    longint        x, y, w, one, turn, cap, maxmag, m;
    longint        spd [N_LANES];
    wheel_result_t res;
    x    = clamp_cmd(sx, chassis_cfg.limit_x);
    y    = clamp_cmd(sy, chassis_cfg.limit_y);
    w    = clamp_cmd(sw, chassis_cfg.limit_turn);
    one  = longint'(1) << TURN_FRAC;
    turn = w * longint'(chassis_cfg.turn_ratio);
    spd[0] = wheel_rpm_of(( x + y) * one + turn);
    spd[1] = wheel_rpm_of((-x + y) * one + turn);
    spd[2] = wheel_rpm_of((-x - y) * one + turn);
    spd[3] = wheel_rpm_of(( x - y) * one + turn);
    maxmag = 0;
    for (int i = 0; i < N_LANES; i++) begin
      m = (spd[i] < 0) ? -spd[i] : spd[i];
      if (m > maxmag) maxmag = m;
    end
    // Scale all wheels in proportion when the largest exceeds the wheel limit
    cap = longint'(chassis_cfg.wheel_limit);
    res.scaled = (maxmag > cap);
    for (int i = 0; i < N_LANES; i++) begin
      if (res.scaled) begin
        m = (spd[i] < 0) ? -spd[i] : spd[i];
        m = (m * cap) / maxmag;
        spd[i] = (spd[i] < 0) ? -m : m;
      end
      res.rpm[i] = WHEEL_W'(spd[i]);
    end
    return res;
  endfunction

  // Random command: in range or full-width, some at the edges, some small
  function automatic logic signed [CMD_W-1:0] pick_speed(logic [LIM_W-1:0] bound);
    int r;
    int b;
    b = int'(bound);
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_W'($urandom);
    if (r < 70) return CMD_W'(int'($urandom_range(0, 2 * b)) - b);
    if (r < 85) begin
      case ($urandom_range(0, 5))
        0: return CMD_W'(-32768);
        1: return CMD_W'(32767);
        2: return CMD_W'(b);
        3: return CMD_W'(-b);
        4: return CMD_W'(b + 1);
        default: return CMD_W'(-b - 1);
      endcase
    end
    return CMD_W'(int'($urandom_range(0, 128)) - 64);
  endfunction

  task automatic add_reg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = CFG_DATA_W'(data);
    stim_rows.push_back(row);
  endtask

  task automatic add_cmd(input int x, input int y, input int w);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CMD;
    row.sx = CMD_W'(x);
    row.sy = CMD_W'(y);
    row.sw = CMD_W'(w);
    stim_rows.push_back(row);
  endtask

  task automatic add_cmd_known(input int x, input int y, input int w, input int r0,
                               input int r1, input int r2, input int r3, input bit sc);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CMD;
    row.sx = CMD_W'(x);
    row.sy = CMD_W'(y);
    row.sw = CMD_W'(w);
    row.fixed = 1'b1;
    row.want.rpm = {WHEEL_W'(r3), WHEEL_W'(r2), WHEEL_W'(r1), WHEEL_W'(r0)};
    row.want.scaled = sc;
    stim_rows.push_back(row);
  endtask

  // Write one register once the pipeline has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    do @(negedge clk); while (wheel_expect_q.size() != 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LIMIT_X:     chassis_cfg.limit_x     = data[LIM_W-1:0];
      CFG_LIMIT_Y:     chassis_cfg.limit_y     = data[LIM_W-1:0];
      CFG_LIMIT_TURN:  chassis_cfg.limit_turn  = data[LIM_W-1:0];
      CFG_TURN_RATIO:  chassis_cfg.turn_ratio  = data[TURN_RATIO_W-1:0];
      CFG_RPM_RATIO:   chassis_cfg.rpm_ratio   = data[RPM_RATIO_W-1:0];
      CFG_WHEEL_LIMIT: chassis_cfg.wheel_limit = data[LIM_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Offer one command after a random gap and queue its expected wheel speeds
  task automatic send_cmd(input logic signed [CMD_W-1:0] sx, input logic signed [CMD_W-1:0] sy,
                          input logic signed [CMD_W-1:0] sw, input logic known,
                          input wheel_result_t want);
    int gap;
    int r;
    gap = 0;
    if (in_calm_left > 0) begin
      in_calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) in_calm_left = $urandom_range(20, 60);
      else if (r < 55) gap = 0;
      else if (r < 93) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_speed_x   <= sx;
    in_speed_y   <= sy;
    in_turn_rate <= sw;
    do @(posedge clk); while (!in_ready);
    wheel_expect_q.push_back(known ? want : mix_wheel_speeds(sx, sy, sw));
  endtask

  // Receiver: mostly ready, short stalls, the odd long one, and calm stretches
  always @(posedge clk) begin
    int r;
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_calm_left > 0) begin
        out_calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) out_calm_left = $urandom_range(30, 100);
        else if (r < 30) out_stall_left = $urandom_range(1, 3);
        else if (r < 34) out_stall_left = $urandom_range(10, 50);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    wheel_result_t got;
    wheel_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.rpm = {out_wheel3_rpm, out_wheel2_rpm, out_wheel1_rpm, out_wheel0_rpm};
      got.scaled = out_was_scaled;
      if (wheel_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got %0d %0d %0d %0d scaled %0b",
                   $time, $signed(got.rpm[0]), $signed(got.rpm[1]), $signed(got.rpm[2]),
                   $signed(got.rpm[3]), got.scaled);
      end else begin
        want = wheel_expect_q.pop_front();
        for (int i = 0; i < N_LANES; i++) begin
          if (got.rpm[i] !== want.rpm[i]) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: wheel%0d rpm expected %0d, got %0d", $time, i,
                       $signed(want.rpm[i]), $signed(got.rpm[i]));
          end
        end
        if (got.scaled !== want.scaled) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: was_scaled expected %0b, got %0b", $time, want.scaled, got.scaled);
        end
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] value;
    int                    r;

    chassis_cfg.limit_x     = LIMIT_X_RST;
    chassis_cfg.limit_y     = LIMIT_Y_RST;
    chassis_cfg.limit_turn  = LIMIT_TURN_RST;
    chassis_cfg.turn_ratio  = TURN_RATIO_RST;
    chassis_cfg.rpm_ratio   = RPM_RATIO_RST;
    chassis_cfg.wheel_limit = WHEEL_LIMIT_RST;

    // Directed table: reset defaults, field extremes, then the special cases
    add_cmd_known(0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_cmd(32767, 32767, 32767);
    add_cmd(-32768, -32768, -32768);
    add_cmd(32767, -32768, 0);
    add_cmd(0, 0, 32767);
    add_cmd(1234, -2345, -150);
    // Widest clamps and ratio: mixes saturate, then scale to the wheel limit
    add_reg_write(CFG_LIMIT_X, 32767);
    add_reg_write(CFG_LIMIT_Y, 32767);
    add_reg_write(CFG_TURN_RATIO, 0);
    add_reg_write(CFG_RPM_RATIO, 24'hFFFFFF);
    add_cmd_known(32767, 32767, 0, 8500, 0, -8500, 0, 1'b1);
    add_cmd_known(-32768, 0, 0, -8500, 8500, 8500, -8500, 1'b1);
    add_cmd(0, -32768, 32767);
    // Zero wheel limit: any motion zeroes every wheel and flags scaling
    add_reg_write(CFG_WHEEL_LIMIT, 0);
    add_cmd_known(1000, 0, 0, 0, 0, 0, 0, 1'b1);
    add_cmd_known(0, 0, 0, 0, 0, 0, 0, 1'b0);
    // Over-wide data keeps only the low bits, here giving a zero x clamp
    add_reg_write(CFG_LIMIT_X, 24'hFF8000);
    add_cmd_known(32767, 0, 0, 0, 0, 0, 0, 1'b0);
    // Writes past the register list change nothing
    add_reg_write(CFG_SPARE_LO, 0);
    add_reg_write(CFG_SPARE_HI, 0);
    add_reg_write(CFG_WHEEL_LIMIT, 24'hFFFFFF);
    add_reg_write(CFG_LIMIT_TURN, 32767);
    add_reg_write(CFG_TURN_RATIO, 65535);
    add_cmd(0, 0, -32768);
    add_cmd(32767, -32768, 32767);
    add_cmd(-1, 1, -1);
    add_reg_write(CFG_LIMIT_Y, 0);
    add_cmd(0, -32768, 100);
    add_reg_write(CFG_WHEEL_LIMIT, 1);
    add_cmd(0, 0, 3);
    add_cmd(-5, 7, -3);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[k]) begin
      if (stim_rows[k].kind == ROW_CFG)
        write_reg(stim_rows[k].idx, stim_rows[k].data);
      else
        send_cmd(stim_rows[k].sx, stim_rows[k].sy, stim_rows[k].sw,
                 stim_rows[k].fixed, stim_rows[k].want);
    end

    // Random phases: all maxima, all zero, reset values, then random settings
    for (int phase = 0; phase < N_PHASES; phase++) begin
      for (int ri = 0; ri < N_REGS; ri++) begin
        r = $urandom_range(0, 99);
        case (phase)
          0: value = '1;
          1: value = '0;
          2: begin
            case (cfg_idx_t'(ri))
              CFG_LIMIT_X:    value = CFG_DATA_W'(LIMIT_X_RST);
              CFG_LIMIT_Y:    value = CFG_DATA_W'(LIMIT_Y_RST);
              CFG_LIMIT_TURN: value = CFG_DATA_W'(LIMIT_TURN_RST);
              CFG_TURN_RATIO: value = CFG_DATA_W'(TURN_RATIO_RST);
              CFG_RPM_RATIO:  value = CFG_DATA_W'(RPM_RATIO_RST);
              default:        value = CFG_DATA_W'(WHEEL_LIMIT_RST);
            endcase
          end
          default: begin
            case (cfg_idx_t'(ri))
              CFG_LIMIT_X, CFG_LIMIT_Y, CFG_LIMIT_TURN:
                value = (r < 50) ? CFG_DATA_W'($urandom_range(0, 4000)) : CFG_DATA_W'($urandom);
              CFG_TURN_RATIO:
                value = (r < 50) ? CFG_DATA_W'($urandom_range(0, 4000)) : CFG_DATA_W'($urandom);
              CFG_RPM_RATIO:
                value = (r < 50) ? CFG_DATA_W'($urandom_range(0, 1 << 20)) : CFG_DATA_W'($urandom);
              default:
                value = (r < 30) ? CFG_DATA_W'($urandom_range(0, 64)) : CFG_DATA_W'($urandom);
            endcase
          end
        endcase
        write_reg(CFG_IDX_W'(ri), value);
      end
      if (phase > 1 && $urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
      repeat (CMDS_PER_PHASE)
        send_cmd(pick_speed(chassis_cfg.limit_x), pick_speed(chassis_cfg.limit_y),
                 pick_speed(chassis_cfg.limit_turn), 1'b0, '0);
    end

    // Drain, allow for stragglers, then report
    in_valid <= 1'b0;
    do @(negedge clk); while (wheel_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mwsm_pkg.sv
hw/rtl/mwsm_mix.sv
hw/rtl/mwsm_scale.sv
hw/rtl/mwsm_div.sv
hw/rtl/mecanum_wheel_speed_mixer_unit.sv
tb/sv/mecanum_wheel_speed_mixer_unit_test.sv
